@@ rtl/hfpr_pkg.sv @@
package hfpr_pkg;

  // frame buffer geometry
  localparam int MAX_FRAME = 64;
  localparam int LEN_LIMIT = (MAX_FRAME < 64) ? MAX_FRAME : 64;
  localparam int ADDR_W    = $clog2(MAX_FRAME);
  localparam int CNT_W     = 7;

  // crc-16/ccitt-false
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HDR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOC_HDR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS_HDR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOC_LEN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS_LEN = 3'd5;

  // minimum frame lengths
  localparam logic [CNT_W-1:0] MIN_LEN_SHORT = 7'd3;
  localparam logic [CNT_W-1:0] MIN_LEN_LOC   = 7'd4;

  typedef enum logic [1:0] {
    KIND_TEMP   = 2'd0,
    KIND_LOC    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  // commands to the bit-serial crc unit
  typedef struct packed {
    logic       init;
    logic       start;
    logic [7:0] data;
  } crc_cmd_t;

  // status back from the crc unit
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] crc;
  } crc_stat_t;

  // saturate a configured length into the legal range
  function automatic logic [CNT_W-1:0] clamp_len(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] lo);
    logic [CNT_W-1:0] hi;
    logic [CNT_W-1:0] res;
    hi  = CNT_W'(LEN_LIMIT);
    res = v;
    if (v < lo) begin
      res = lo;
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

endpackage

@@ rtl/hfpr_if.sv @@
// received byte channel
interface hfpr_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

// result channel
interface hfpr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_kind;
  logic       check_status;
  logic [7:0] payload_byte;
  logic       last;

  modport source (output valid, output frame_kind, output check_status,
                  output payload_byte, output last, input ready);
  modport sink   (input valid, input frame_kind, input check_status,
                  input payload_byte, input last, output ready);
endinterface

// configuration write channel
interface hfpr_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/hfpr_ram.sv @@
module hfpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/hfpr_crc.sv @@
module hfpr_crc (
  input  logic               clk,
  input  logic               rst_n,
  input  hfpr_pkg::crc_cmd_t cmd,
  output hfpr_pkg::crc_stat_t stat
);
  import hfpr_pkg::*;

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic [7:0]  sh_r;
  logic [2:0]  bit_cnt_r;
  logic        busy_r;
  logic        fb;

  // one message bit per cycle, msb first
  always_comb begin
    fb      = crc_r[15] ^ sh_r[7];
    crc_nxt = {crc_r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r     <= CRC_INIT;
      busy_r    <= 1'b0;
      bit_cnt_r <= 3'd0;
    end else begin
      if (cmd.start) begin
        crc_r     <= cmd.init ? CRC_INIT : crc_r;
        sh_r      <= cmd.data;
        busy_r    <= 1'b1;
        bit_cnt_r <= 3'd0;
      end else if (cmd.init) begin
        crc_r <= CRC_INIT;
      end else if (busy_r) begin
        crc_r     <= crc_nxt;
        sh_r      <= {sh_r[6:0], 1'b0};
        bit_cnt_r <= bit_cnt_r + 3'd1;
        if (bit_cnt_r == 3'd7) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (bit_cnt_r == 3'd7);
  assign stat.crc  = crc_r;

endmodule

@@ rtl/header_framed_packet_receiver_crc16.sv @@
// Header-framed packet receiver with CRC-16/CCITT-FALSE check.
// in_ch takes one item per received byte (operation 0) or a line idle gap
// (operation 1, drops a partial frame). A byte matching one of the three
// configured headers opens a temperature, location or status frame.
// out_ch delivers result items: the payload run of a good location frame,
// byte1 of a good temperature or status frame, or one error item; last
// marks the final item of each frame.
// cfg_ch writes the header and length registers (always ready); write only
// while the block is idle.
// A byte that does not close a frame is taken in the idle state; a location
// byte covered by the CRC then waits out the 8 bit-serial steps of the crc unit.
// A closing byte passes through accept, check and emit. A good location frame
// instead passes accept and check, then streams its payload out with a read
// and an emit state per item, for the frame buffer's registered read.
// in_ch is not ready while the crc runs or results are pending.
// Reset restores the register defaults and returns to header hunting.
// A stalled receiver holds the output register; the sequencer waits in the
// emit state for it to free, and no result is lost.
module header_framed_packet_receiver_crc16 (
  input logic         clk,
  input logic         rst_n,
  hfpr_in_if.sink     in_ch,
  hfpr_out_if.source  out_ch,
  hfpr_cfg_if.sink    cfg_ch
);
  import hfpr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRC,
    S_CHECK,
    S_RD,
    S_EMIT
  } state_t;

  // configuration registers
  logic [7:0]       temp_hdr_r, loc_hdr_r, status_hdr_r;
  logic [CNT_W-1:0] temp_len_r, loc_len_r, status_len_r;

  // frame control
  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  kind_t            kind_r;
  logic [CNT_W-1:0] exp_len_r;
  logic [CNT_W-1:0] idx_r;

  // captured bytes
  logic [7:0] b0_r, b1_r, b2_r, prev_r, last_r;

  // pending result item
  logic       pend_status_r;
  logic       pend_last_r;
  logic       pend_ram_r;
  logic [7:0] pend_payload_r;

  // output register
  logic       out_valid_r;
  kind_t      out_kind_r;
  logic       out_status_r;
  logic [7:0] out_payload_r;
  logic       out_last_r;

  logic             in_acc, take_byte, start_frame, hit_any;
  logic             hit_temp, hit_loc, hit_status;
  kind_t            hdr_kind, cur_kind;
  logic [CNT_W-1:0] hdr_len, cur_len, count_inc;
  logic             need_crc, complete, out_free, crc_ok, xor_ok;
  logic [7:0]       ram_rdata;
  crc_cmd_t         crc_cmd;
  crc_stat_t        crc_stat;

  // configuration writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_hdr_r   <= 8'd1;
      loc_hdr_r    <= 8'd2;
      status_hdr_r <= 8'd3;
      temp_len_r   <= 7'd3;
      loc_len_r    <= 7'd35;
      status_len_r <= 7'd3;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_TEMP_HDR:   temp_hdr_r   <= cfg_ch.data;
        CFG_LOC_HDR:    loc_hdr_r    <= cfg_ch.data;
        CFG_STATUS_HDR: status_hdr_r <= cfg_ch.data;
        CFG_TEMP_LEN:   temp_len_r   <= cfg_ch.data[CNT_W-1:0];
        CFG_LOC_LEN:    loc_len_r    <= cfg_ch.data[CNT_W-1:0];
        CFG_STATUS_LEN: status_len_r <= cfg_ch.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // header match, temperature first, then location, then status
  always_comb begin
    hit_temp   = in_ch.rx_byte == temp_hdr_r;
    hit_loc    = in_ch.rx_byte == loc_hdr_r;
    hit_status = in_ch.rx_byte == status_hdr_r;
    hit_any    = hit_temp || hit_loc || hit_status;
    priority if (hit_temp) begin
      hdr_kind = KIND_TEMP;
      hdr_len  = clamp_len(temp_len_r, MIN_LEN_SHORT);
    end else if (hit_loc) begin
      hdr_kind = KIND_LOC;
      hdr_len  = clamp_len(loc_len_r, MIN_LEN_LOC);
    end else begin
      hdr_kind = KIND_STATUS;
      hdr_len  = clamp_len(status_len_r, MIN_LEN_SHORT);
    end
  end

  // per-byte decisions
  always_comb begin
    in_acc      = in_ch.valid && in_ch.ready;
    start_frame = (count_r == '0) && hit_any;
    take_byte   = in_acc && !in_ch.operation && ((count_r != '0) || hit_any);
    cur_kind    = (count_r == '0) ? hdr_kind : kind_r;
    cur_len     = (count_r == '0) ? hdr_len : exp_len_r;
    count_inc   = count_r + 7'd1;
    need_crc    = (cur_kind == KIND_LOC) &&
                  (({1'b0, count_inc} + 8'd2) <= {1'b0, cur_len});
    complete    = count_inc == cur_len;
    out_free    = !out_valid_r || out_ch.ready;
    crc_ok      = {last_r, prev_r} == crc_stat.crc;
    xor_ok      = b2_r == (b0_r ^ b1_r);
  end

  // crc unit commands
  always_comb begin
    crc_cmd.init  = in_acc && (in_ch.operation || start_frame);
    crc_cmd.start = take_byte && need_crc;
    crc_cmd.data  = in_ch.rx_byte;
  end

  hfpr_crc u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (crc_cmd),
    .stat  (crc_stat)
  );

  hfpr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FRAME)
  ) u_buf (
    .clk   (clk),
    .we    (take_byte),
    .waddr (ADDR_W'(count_r)),
    .wdata (in_ch.rx_byte),
    .re    (state_r == S_RD),
    .raddr (ADDR_W'(idx_r)),
    .rdata (ram_rdata)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      kind_r      <= KIND_TEMP;
      exp_len_r   <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the emit state reloads the output register itself
      if (out_valid_r && out_ch.ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_ch.operation) begin
            count_r <= '0;
          end else if (take_byte) begin
            kind_r    <= cur_kind;
            exp_len_r <= cur_len;
            prev_r    <= last_r;
            last_r    <= in_ch.rx_byte;
            if (count_r == 7'd0) b0_r <= in_ch.rx_byte;
            if (count_r == 7'd1) b1_r <= in_ch.rx_byte;
            if (count_r == 7'd2) b2_r <= in_ch.rx_byte;
            if (complete) begin
              count_r <= '0;
              state_r <= S_CHECK;
            end else begin
              count_r <= count_inc;
              if (need_crc) state_r <= S_CRC;
            end
          end
        end
        S_CRC: begin
          if (crc_stat.done) state_r <= S_IDLE;
        end
        S_CHECK: begin
          pend_ram_r  <= 1'b0;
          pend_last_r <= 1'b1;
          if (kind_r == KIND_LOC) begin
            pend_status_r  <= 1'b1;
            pend_payload_r <= 8'd0;
            if (crc_ok) begin
              idx_r   <= 7'd1;
              state_r <= S_RD;
            end else begin
              state_r <= S_EMIT;
            end
          end else begin
            pend_status_r  <= !xor_ok;
            pend_payload_r <= xor_ok ? b1_r : 8'd0;
            state_r        <= S_EMIT;
          end
        end
        S_RD: begin
          pend_ram_r    <= 1'b1;
          pend_status_r <= 1'b0;
          pend_last_r   <= ({1'b0, idx_r} + 8'd3) == {1'b0, exp_len_r};
          state_r       <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_kind_r    <= kind_r;
            out_status_r  <= pend_status_r;
            out_payload_r <= pend_ram_r ? ram_rdata : pend_payload_r;
            out_last_r    <= pend_last_r;
            if (pend_last_r) begin
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + 7'd1;
              state_r <= S_RD;
            end
          end else if (out_ch.ready) begin
            out_valid_r <= 1'b0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = state_r == S_IDLE;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_kind   = out_kind_r;
  assign out_ch.check_status = out_status_r;
  assign out_ch.payload_byte = out_payload_r;
  assign out_ch.last         = out_last_r;

  // a partial frame never reaches its latched length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 |-> count_r < exp_len_r)
    else $error("byte count reached the frame length without closing");

  // the check runs only after the count went back to hunting
  a_check_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK |-> count_r == '0)
    else $error("frame check with a partial count");

  // payload reads stay inside the location payload
  a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |-> kind_r == KIND_LOC && idx_r != '0 &&
      ({1'b0, idx_r} + 8'd3) <= {1'b0, exp_len_r})
    else $error("payload read out of range");

  // crc steps finish only while the sequencer waits for them
  a_crc_done: assert property (@(posedge clk) disable iff (!rst_n)
    crc_stat.done |-> state_r == S_CRC)
    else $error("crc unit finished outside the crc wait");

  // no item is taken while the crc unit still shifts
  a_crc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !crc_stat.busy)
    else $error("item accepted while the crc unit is busy");

endmodule
